// ===== rtl/core/wal_pkg.sv =====
`timescale 1ns / 1ps

package wal_pkg;

  localparam int TIME_W      = 31;
  localparam int COUNT_W     = 16;
  localparam int CFG_DATA_W  = 31;
  localparam int CFG_INDEX_W = 2;
  localparam int WHY_W       = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LENGTH   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_QUOTA    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MINIMUM_GAP     = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_COOLDOWN_LENGTH = 2'd3;

  localparam logic [TIME_W-1:0]  RESET_WINDOW_LENGTH   = 31'd10000;
  localparam logic [COUNT_W-1:0] RESET_WINDOW_QUOTA    = 16'd3;
  localparam logic [TIME_W-1:0]  RESET_MINIMUM_GAP     = 31'd500;
  localparam logic [TIME_W-1:0]  RESET_COOLDOWN_LENGTH = 31'd3000;

  typedef enum logic [WHY_W-1:0] {
    WHY_NONE     = 3'd0,
    WHY_MAINT    = 3'd1,
    WHY_COOLDOWN = 3'd2,
    WHY_GAP      = 3'd3,
    WHY_WINDOW   = 3'd4
  } why_t;

  typedef struct packed {
    logic [TIME_W-1:0]  window_length;
    logic [COUNT_W-1:0] window_quota;
    logic [TIME_W-1:0]  minimum_gap;
    logic [TIME_W-1:0]  cooldown_length;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0]  window_begin;
    logic [COUNT_W-1:0] window_count;
    logic [TIME_W-1:0]  last_accept_time;
    logic               last_accept_valid;
    logic [TIME_W:0]    cooldown_end;
  } state_t;

  typedef struct packed {
    logic [TIME_W-1:0] timestamp;
    logic              maintenance;
    logic              emergency;
  } req_t;

  typedef struct packed {
    logic accepted;
    why_t why;
  } verdict_t;

endpackage

// ===== rtl/core/wal_req_if.sv =====
`timescale 1ns / 1ps

interface wal_req_if;
  logic                      valid;
  logic                      ready;
  logic [wal_pkg::TIME_W-1:0] timestamp;
  logic                      maintenance;
  logic                      emergency;

  modport source (output valid, output timestamp, output maintenance, output emergency,
                  input ready);
  modport sink (input valid, input timestamp, input maintenance, input emergency,
                output ready);
endinterface

// ===== rtl/core/wal_res_if.sv =====
`timescale 1ns / 1ps

interface wal_res_if;
  logic                      valid;
  logic                      ready;
  logic                      accepted;
  logic [wal_pkg::WHY_W-1:0] why;

  modport source (output valid, output accepted, output why, input ready);
  modport sink (input valid, input accepted, input why, output ready);
endinterface

// ===== rtl/core/wal_judge.sv =====
`timescale 1ns / 1ps

module wal_judge (
  input  wal_pkg::req_t     item,
  input  wal_pkg::state_t   st,
  input  wal_pkg::cfg_t     cfg,
  output wal_pkg::verdict_t verdict,
  output wal_pkg::state_t   st_next
);

  logic [wal_pkg::TIME_W:0]    now_ext;
  logic [wal_pkg::TIME_W:0]    window_end;
  logic [wal_pkg::TIME_W:0]    gap_end;
  logic                        roll;
  logic                        gap_short;
  logic [wal_pkg::COUNT_W-1:0] count_eff;

  always_comb begin
    now_ext    = {1'b0, item.timestamp};
    window_end = {1'b0, st.window_begin} + {1'b0, cfg.window_length};
    gap_end    = {1'b0, st.last_accept_time} + {1'b0, cfg.minimum_gap};
    roll       = now_ext >= window_end;
    gap_short  = st.last_accept_valid && (now_ext < gap_end);
    count_eff  = roll ? '0 : st.window_count;

    st_next              = st;
    st_next.window_count = count_eff;
    if (roll) begin
      st_next.window_begin = item.timestamp;
    end

    verdict.accepted = 1'b0;
    priority if (item.maintenance && !item.emergency) begin
      verdict.why = wal_pkg::WHY_MAINT;
    end else if (now_ext < st.cooldown_end) begin
      verdict.why = wal_pkg::WHY_COOLDOWN;
    end else if (gap_short) begin
      verdict.why = wal_pkg::WHY_GAP;
    end else if (count_eff >= cfg.window_quota) begin
      verdict.why          = wal_pkg::WHY_WINDOW;
      st_next.cooldown_end = now_ext + {1'b0, cfg.cooldown_length};
    end else begin
      verdict.why               = wal_pkg::WHY_NONE;
      verdict.accepted          = 1'b1;
      st_next.last_accept_time  = item.timestamp;
      st_next.last_accept_valid = 1'b1;
      st_next.window_count      = count_eff + 1'b1;
    end
  end

endmodule

// ===== rtl/core/windowed_admission_limiter.sv =====
`timescale 1ns / 1ps

// Fixed-window admission limiter. Each request transfer yields exactly one result transfer
// carrying accepted and a reason code, in request order. A request is registered on entry and
// judged from that register against the window, gap and cooldown state, which is updated
// at the same edge that loads the result register; the next request therefore sees the new
// state at once. The block sustains one request per cycle, passing each through the item
// register and then the result register, and only a stalled result side slows it down.
// Configuration writes take effect at the next edge and are meant for idle periods.

module windowed_admission_limiter (
  input  logic                               clk,
  input  logic                               rst,
  wal_req_if.sink                            req,
  wal_res_if.source                          res,
  input  logic                               cfg_we,
  input  logic [wal_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [wal_pkg::CFG_DATA_W-1:0]     cfg_data
);

  wal_pkg::cfg_t     cfg;
  wal_pkg::state_t   st;
  wal_pkg::state_t   st_next;
  wal_pkg::req_t     item;
  wal_pkg::verdict_t verdict;
  logic              item_valid;
  logic              advance;

  assign advance   = item_valid && (!res.valid || res.ready);
  assign req.ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_length   <= wal_pkg::RESET_WINDOW_LENGTH;
      cfg.window_quota    <= wal_pkg::RESET_WINDOW_QUOTA;
      cfg.minimum_gap     <= wal_pkg::RESET_MINIMUM_GAP;
      cfg.cooldown_length <= wal_pkg::RESET_COOLDOWN_LENGTH;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wal_pkg::REG_WINDOW_LENGTH: begin
          cfg.window_length <= cfg_data[wal_pkg::TIME_W-1:0];
        end
        wal_pkg::REG_WINDOW_QUOTA: begin
          cfg.window_quota <= cfg_data[wal_pkg::COUNT_W-1:0];
        end
        wal_pkg::REG_MINIMUM_GAP: begin
          cfg.minimum_gap <= cfg_data[wal_pkg::TIME_W-1:0];
        end
        wal_pkg::REG_COOLDOWN_LENGTH: begin
          cfg.cooldown_length <= cfg_data[wal_pkg::TIME_W-1:0];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (req.ready) begin
      item_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      item.timestamp   <= req.timestamp;
      item.maintenance <= req.maintenance;
      item.emergency   <= req.emergency;
    end
  end

  wal_judge u_judge (
    .item    (item),
    .st      (st),
    .cfg     (cfg),
    .verdict (verdict),
    .st_next (st_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (advance) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res.accepted <= verdict.accepted;
      res.why      <= verdict.why;
    end
  end

`ifndef SYNTHESIS
  a_accept_records: assert property (@(posedge clk) disable iff (rst)
    (advance && verdict.accepted) |=>
      (st.last_accept_valid && st.last_accept_time == $past(item.timestamp)))
    else $error("accepted request did not record its time");

  a_limit_cooldown: assert property (@(posedge clk) disable iff (rst)
    (advance && verdict.why == wal_pkg::WHY_WINDOW) |=>
      (st.cooldown_end == $past({1'b0, item.timestamp} + {1'b0, cfg.cooldown_length})))
    else $error("window limit did not restart the cooldown");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (item_valid && res.valid && !res.ready) |-> !req.ready)
    else $error("request taken while both stages are stalled");

  a_result_code: assert property (@(posedge clk) disable iff (rst)
    advance |=> (res.accepted == (res.why == wal_pkg::WHY_NONE)))
    else $error("result flag and reason code disagree");
`endif

endmodule
